### rtl/tkfl_pkg.sv
`timescale 1ns / 1ps

package tkfl_pkg;

  localparam int DistW = 32;
  localparam int IdW   = 32;

  // empty slot marker, most negative q16.16 value
  localparam logic signed [DistW-1:0] EMPTY_DIST = {1'b1, {(DistW-1){1'b0}}};

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic signed [DistW-1:0] dval;
    logic [IdW-1:0]          desc;
    logic [IdW-1:0]          clu;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{dval: EMPTY_DIST, desc: '0, clu: '0};

  // per-cell command from the top level
  typedef struct packed {
    logic insert;
    logic clear;
    logic in_use;
  } cell_ctrl_t;

  // per-cell compare status toward the top level and the right neighbor
  typedef struct packed {
    logic ge;
    logic take_new;
  } cell_stat_t;

endpackage

### rtl/tkfl_cell.sv
`timescale 1ns / 1ps

module tkfl_cell (
  input  logic            clk,
  input  logic            rst,
  input  tkfl_pkg::cell_ctrl_t ctrl,
  input  tkfl_pkg::entry_t     cand,
  input  tkfl_pkg::entry_t     left_entry,
  input  logic            left_ge,
  output tkfl_pkg::entry_t     entry,
  output tkfl_pkg::cell_stat_t stat
);
  import tkfl_pkg::*;

  entry_t entry_next;

  // held entry stays ahead of an equal candidate
  assign stat.ge       = (entry.dval >= cand.dval);
  assign stat.take_new = ctrl.in_use & ~stat.ge & left_ge;

  always_comb begin
    entry_next = entry;
    if (ctrl.clear) begin
      entry_next = EMPTY_ENTRY;
    end else if (ctrl.insert && ctrl.in_use && !stat.ge) begin
      entry_next = left_ge ? cand : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= EMPTY_ENTRY;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

### rtl/top_k_farthest_list.sv
`timescale 1ns / 1ps
// channel  | handshake                     | beat contents
// ---------+-------------------------------+----------------------------------------------
// in       | in_valid / in_ready           | command, descriptor_id, cluster_id,
//          |                               | distance, read_index
// out      | out_valid / out_ready         | accepted, placed_slot, held_count, slot_valid,
//          |                               | slot_descriptor, slot_cluster, slot_distance
// cfg      | cfg_write_en / cfg_write_data | active_k, written with no wait
//
// for every beat, all cells compare and shift in parallel at the input edge,
// and the result lands in the output register on the same edge.
// one beat per cycle is sustained while out_ready stays high; the output register
// is the only buffer, so a stalled result holds off the next input beat.
// reset (synchronous) empties all cells, zeroes the fill count and sets active_k to MAX_K.
module top_k_farthest_list #(
  parameter int MAX_K = 16
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] descriptor_id,
  input  logic [31:0] cluster_id,
  input  logic signed [31:0] distance,
  input  logic [3:0]  read_index,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [3:0]  placed_slot,
  output logic [4:0]  held_count,
  output logic        slot_valid,
  output logic [31:0] slot_descriptor,
  output logic [31:0] slot_cluster,
  output logic signed [31:0] slot_distance,

  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data
);
  import tkfl_pkg::*;

  // count width holds 0..MAX_K
  localparam int CW   = $clog2(MAX_K + 1);
  // common width for comparing the 4-bit read index against counts
  localparam int CMPW = (CW > 4) ? CW : 4;

  // chain of cells, slot 0 holds the largest distance
  entry_t     entries [MAX_K];
  cell_stat_t stats   [MAX_K];
  cell_ctrl_t ctrls   [MAX_K];
  entry_t     cand;

  logic [CW-1:0] active_k;
  logic [CW-1:0] active_k_next;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_count_next;
  logic [CW-1:0] cfg_k;

  logic          in_fire;
  logic          is_insert;
  logic          is_read;
  logic          is_clear;
  logic          do_insert;
  logic          last_lt;
  logic [MAX_K-1:0] take_new_vec;
  logic [3:0]    placed;

  logic [CMPW-1:0] rd_ext;
  logic            rd_ok;
  entry_t          rd_entry;

  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign is_insert = (command == CMD_INSERT);
  assign is_read   = (command == CMD_READ);
  assign is_clear  = (command == CMD_CLEAR);

  assign cand = '{dval: distance, desc: descriptor_id, clu: cluster_id};

  // clamp the written size to 1..MAX_K
  always_comb begin
    if (cfg_write_data == 5'd0) begin
      cfg_k = CW'(1);
    end else if (int'(cfg_write_data) > MAX_K) begin
      cfg_k = CW'(MAX_K);
    end else begin
      cfg_k = CW'(cfg_write_data);
    end
  end

  // candidate beats the last active slot, which is empty while not full
  always_comb begin
    last_lt = 1'b0;
    for (int i = 0; i < MAX_K; i++) begin
      if (active_k == CW'(i + 1)) begin
        last_lt = ~stats[i].ge;
      end
    end
  end

  assign do_insert = in_fire & is_insert & last_lt;

  // per-cell control
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      ctrls[i].in_use = (CW'(i) < active_k);
      ctrls[i].insert = do_insert;
      ctrls[i].clear  = (in_fire & is_clear) | (cfg_write_en & (CW'(i) >= cfg_k));
    end
  end

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    tkfl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrls[g]),
      .cand       (cand),
      .left_entry ((g == 0) ? EMPTY_ENTRY : entries[(g == 0) ? 0 : g - 1]),
      .left_ge    ((g == 0) ? 1'b1 : stats[(g == 0) ? 0 : g - 1].ge),
      .entry      (entries[g]),
      .stat       (stats[g])
    );
    assign take_new_vec[g] = stats[g].take_new;
  end

  // slot where the candidate lands, cut to the 4-bit field
  always_comb begin
    placed = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if (take_new_vec[i]) begin
        placed = placed | 4'(i);
      end
    end
  end

  // read select
  assign rd_ext = CMPW'(read_index);
  assign rd_ok  = (rd_ext < CMPW'(active_k)) && (rd_ext < CMPW'(fill_count));

  always_comb begin
    rd_entry = EMPTY_ENTRY;
    for (int i = 0; i < MAX_K; i++) begin
      if (rd_ok && (rd_ext == CMPW'(i))) begin
        rd_entry = entries[i];
      end
    end
  end

  // size and fill bookkeeping
  always_comb begin
    active_k_next   = active_k;
    fill_count_next = fill_count;
    if (cfg_write_en) begin
      active_k_next = cfg_k;
      if (fill_count > cfg_k) begin
        fill_count_next = cfg_k;
      end
    end else if (in_fire && is_clear) begin
      fill_count_next = '0;
    end else if (do_insert && (fill_count < active_k)) begin
      fill_count_next = fill_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_k   <= CW'(MAX_K);
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      active_k   <= active_k_next;
      fill_count <= fill_count_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      accepted        <= do_insert;
      placed_slot     <= do_insert ? placed : 4'd0;
      held_count      <= 5'(fill_count_next);
      slot_valid      <= is_read & rd_ok;
      slot_descriptor <= is_read ? rd_entry.desc : '0;
      slot_cluster    <= is_read ? rd_entry.clu : '0;
      slot_distance   <= is_read ? rd_entry.dval : EMPTY_DIST;
    end
  end

  // fill count never passes the active size
  assert property (@(posedge clk) disable iff (rst) fill_count <= active_k)
    else $error("fill count above active size");

  // active size stays within 1..MAX_K
  assert property (@(posedge clk) disable iff (rst)
    (active_k != '0) && (active_k <= CW'(MAX_K)))
    else $error("active size out of range");

  // at most one cell takes the candidate
  assert property (@(posedge clk) disable iff (rst) $onehot0(take_new_vec))
    else $error("candidate placed in more than one cell");

  // an accepted insert always finds a cell
  assert property (@(posedge clk) disable iff (rst) do_insert |-> $onehot(take_new_vec))
    else $error("accepted insert without a landing cell");

  // an insert into a list that is not full grows it by one
  assert property (@(posedge clk) disable iff (rst)
    (do_insert && !cfg_write_en && (fill_count < active_k))
      |=> (fill_count == $past(fill_count) + CW'(1)))
    else $error("fill count did not grow on insert");

  // only an insert reports accepted
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_insert) |=> !accepted)
    else $error("accepted flag on a non-insert beat");

endmodule

### tb/sv/top_k_farthest_list_tb.sv
`timescale 1ns / 1ps

module top_k_farthest_list_tb;
  import tkfl_pkg::*;

  localparam int MAX_K = 16;
  // command code the block must ignore
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [31:0] descriptor_id;
  logic [31:0] cluster_id;
  logic signed [31:0] distance;
  logic [3:0]  read_index;
  logic        out_valid;
  logic        out_ready;
  logic        accepted;
  logic [3:0]  placed_slot;
  logic [4:0]  held_count;
  logic        slot_valid;
  logic [31:0] slot_descriptor;
  logic [31:0] slot_cluster;
  logic signed [31:0] slot_distance;
  logic        cfg_write_en;
  logic [4:0]  cfg_write_data;

  top_k_farthest_list #(.MAX_K(MAX_K)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .descriptor_id  (descriptor_id),
    .cluster_id     (cluster_id),
    .distance       (distance),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .placed_slot    (placed_slot),
    .held_count     (held_count),
    .slot_valid     (slot_valid),
    .slot_descriptor(slot_descriptor),
    .slot_cluster   (slot_cluster),
    .slot_distance  (slot_distance),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // one result beat as the block should produce it
  typedef struct {
    logic        accepted;
    logic [3:0]  placed;
    logic [4:0]  held;
    logic        valid;
    logic [31:0] desc;
    logic [31:0] clu;
    logic signed [31:0] dval;
  } list_result_t;

  // shadow copy of the ranked list, slot 0 holds the largest distance
  logic signed [31:0] rank_dist [MAX_K];
  logic [31:0]        rank_desc [MAX_K];
  logic [31:0]        rank_clu  [MAX_K];
  int                 filled;
  int                 k_now;

  list_result_t pending_results[$];
  int           errors;
  bit           steady_flow;   // when set, neither side inserts gaps

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow list
  // ---------------------------------------------------------------------------

  function automatic void empty_from(int first);
    for (int i = first; i < MAX_K; i++) begin
      rank_dist[i] = EMPTY_DIST;
      rank_desc[i] = '0;
      rank_clu[i]  = '0;
    end
  endfunction

  // size register: zero reads as one, anything above MAX_K as MAX_K
  function automatic void apply_size(logic [4:0] value);
    int k;
    k = value;
    if (k < 1) k = 1;
    if (k > MAX_K) k = MAX_K;
    k_now = k;
    empty_from(k);
    if (filled > k) filled = k;
  endfunction

  // update the shadow list for one input beat and return the result it causes
  function automatic list_result_t rank_beat(logic [1:0] cmd, logic [31:0] desc,
                                             logic [31:0] clu, logic signed [31:0] dval,
                                             logic [3:0] ridx);
    list_result_t r;
    int last;
    int p;
    r = '{accepted: 1'b0, placed: '0, held: '0, valid: 1'b0,
          desc: '0, clu: '0, dval: EMPTY_DIST};
    case (cmd)
      CMD_INSERT: begin
        last = k_now - 1;
        // strictly above the last active slot, so the empty marker never gets in
        if (dval > rank_dist[last]) begin
          p = 0;
          // settle behind every entry with an equal or larger distance
          while (p < filled && p < last && rank_dist[p] >= dval) p++;
          for (int i = last; i > p; i--) begin
            rank_dist[i] = rank_dist[i-1];
            rank_desc[i] = rank_desc[i-1];
            rank_clu[i]  = rank_clu[i-1];
          end
          rank_dist[p] = dval;
          rank_desc[p] = desc;
          rank_clu[p]  = clu;
          if (filled < k_now) filled++;
          r.accepted = 1'b1;
          r.placed   = 4'(p);
        end
      end
      CMD_READ: begin
        if (ridx < k_now && ridx < filled) begin
          r.valid = 1'b1;
          r.desc  = rank_desc[ridx];
          r.clu   = rank_clu[ridx];
          r.dval  = rank_dist[ridx];
        end
      end
      CMD_CLEAR: begin
        empty_from(0);
        filled = 0;
      end
      default: begin
        // unknown command leaves the list alone
      end
    endcase
    r.held = 5'(filled);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: check the output beat, then predict the input beat, then config
  // ---------------------------------------------------------------------------

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                   $time, {accepted, placed_slot, held_count, slot_valid});
          errors++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("accepted",        32'(want.accepted), 32'(accepted));
          cmp_field("placed_slot",     32'(want.placed),   32'(placed_slot));
          cmp_field("held_count",      32'(want.held),     32'(held_count));
          cmp_field("slot_valid",      32'(want.valid),    32'(slot_valid));
          cmp_field("slot_descriptor", want.desc,          slot_descriptor);
          cmp_field("slot_cluster",    want.clu,           slot_cluster);
          cmp_field("slot_distance",   want.dval,          slot_distance);
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(rank_beat(command, descriptor_id, cluster_id,
                                            distance, read_index));
      if (cfg_write_en)
        apply_size(cfg_write_data);
    end
  end

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver side stalls
  initial begin : receiver
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (!steady_flow && $urandom_range(0, 99) < 30) hold = pick_gap() + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // one input beat; valid stays up after acceptance until the next falling edge
  task automatic send_beat(logic [1:0] cmd, logic [31:0] desc, logic [31:0] clu,
                           logic signed [31:0] dval, logic [3:0] ridx);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    command       = cmd;
    descriptor_id = desc;
    cluster_id    = clu;
    distance      = dval;
    read_index    = ridx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait until every expected beat has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // size register write, only while the list is idle
  task automatic write_size(logic [4:0] value);
    wait_drained();
    @(negedge clk);
    cfg_write_en   = 1'b1;
    cfg_write_data = value;
    @(negedge clk);
    cfg_write_en   = 1'b0;
  endtask

  // distances: full range, a small pool that forces ties, and the extremes
  function automatic logic signed [31:0] pick_distance();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 70) begin
      v = int'($urandom_range(0, 7)) - 3;
      return v <<< 16;
    end
    if (r < 78) return EMPTY_DIST;
    if (r < 84) return 32'sh7fff_ffff;
    if (r < 90) return EMPTY_DIST + 1;
    v = int'($urandom_range(0, 15)) - 8;
    return v;
  endfunction

  task automatic send_random_beat();
    int r;
    logic [1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 68)      cmd = CMD_INSERT;
    else if (r < 92) cmd = CMD_READ;
    else if (r < 95) cmd = CMD_CLEAR;
    else             cmd = CMD_NONE;
    send_beat(cmd, $urandom, $urandom, pick_distance(), 4'($urandom_range(0, 15)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full size list: empty reads, empty marker, extremes, ties, unknown command, clear
  task automatic test_empty_and_extremes();
    send_beat(CMD_READ,   32'h0,         32'h0,         32'sh0,          4'd0);
    send_beat(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff, EMPTY_DIST,      4'd0);
    send_beat(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'sh7fff_ffff,  4'd15);
    send_beat(CMD_INSERT, 32'h0,         32'h0,         EMPTY_DIST + 1,  4'd0);
    send_beat(CMD_INSERT, 32'h1,         32'ha,         32'sh0001_0000,  4'd0);
    // equal distance settles behind the one already held
    send_beat(CMD_INSERT, 32'h2,         32'hb,         32'sh0001_0000,  4'd0);
    send_beat(CMD_READ,   32'h0,         32'h0,         32'sh0,          4'd2);
    send_beat(CMD_READ,   32'h0,         32'h0,         32'sh0,          4'd15);
    send_beat(CMD_NONE,   32'hdead_beef, 32'h1234_5678, 32'sh7fff_ffff,  4'd1);
    send_beat(CMD_READ,   32'h0,         32'h0,         32'sh0,          4'd0);
    send_beat(CMD_CLEAR,  32'h0,         32'h0,         32'sh0,          4'd0);
    send_beat(CMD_READ,   32'hffff_ffff, 32'hffff_ffff, 32'shffff_ffff,  4'd0);
  endtask

  // size register: zero, one, above the maximum, shrinking a filled list
  task automatic test_list_size();
    write_size(5'd0);
    send_beat(CMD_INSERT, 32'h11, 32'h1, 32'sd5, 4'd0);
    // equal to the last active slot, must be refused
    send_beat(CMD_INSERT, 32'h12, 32'h2, 32'sd5, 4'd0);
    send_beat(CMD_INSERT, 32'h13, 32'h3, 32'sd6, 4'd0);
    send_beat(CMD_READ,   32'h0,  32'h0, 32'sd0, 4'd1);
    write_size(5'd31);
    send_beat(CMD_INSERT, 32'h14, 32'h4, -32'sd1, 4'd0);
    send_beat(CMD_INSERT, 32'h15, 32'h5, 32'sd7,  4'd0);
    // shrink drops the tail
    write_size(5'd1);
    send_beat(CMD_READ,   32'h0,  32'h0, 32'sd0, 4'd0);
    send_beat(CMD_READ,   32'h0,  32'h0, 32'sd0, 4'd1);
    // grow back, the freed slots must read as empty
    write_size(5'd17);
    send_beat(CMD_READ,   32'h0,  32'h0, 32'sd0, 4'd1);
    send_beat(CMD_INSERT, 32'h16, 32'h6, 32'sd0, 4'd0);
  endtask

  // random traffic over several list sizes, with an extra full drain halfway through the fourth phase
  task automatic test_random_traffic();
    int k_plan [8];
    int kv;
    k_plan = '{16, 1, 31, 2, 0, 17, 8, 5};
    for (int ph = 0; ph < 8; ph++) begin
      kv = (ph == 7) ? $urandom_range(0, 31) : k_plan[ph];
      write_size(5'(kv));
      // one phase runs without any gaps on either side
      steady_flow = (ph == 5);
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 50) wait_drained();
        send_random_beat();
      end
      steady_flow = 1'b0;
    end
  endtask

  // back-to-back beats at full rate with the receiver always ready
  task automatic test_full_rate_burst();
    write_size(5'd16);
    steady_flow = 1'b1;
    repeat (40) send_random_beat();
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = CMD_INSERT;
    descriptor_id  = '0;
    cluster_id     = '0;
    distance       = '0;
    read_index     = '0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    errors         = 0;
    steady_flow    = 1'b0;
    // shadow list matches the block after reset
    empty_from(0);
    filled = 0;
    k_now  = MAX_K;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_extremes();
    test_list_size();
    test_random_traffic();
    test_full_rate_burst();

    // let the last beats come back, then a few spare cycles
    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### top_k_farthest_list.f
rtl/tkfl_pkg.sv
rtl/tkfl_cell.sv
rtl/top_k_farthest_list.sv
tb/sv/top_k_farthest_list_tb.sv
